@@ hw/rtl/rqcb_pkg.sv @@
// Shared types, constants and the square-root step for the RMS color blend.
// Used by rqcb_lane, rqcb_side and rgb_quadratic_color_blend_core.
`timescale 1ns / 1ps

package rqcb_pkg;

	typedef enum logic [1:0] {
		CMD_AVG2 = 2'd0,
		CMD_AVG3 = 2'd1,
		CMD_MIX  = 2'd2,
		CMD_LUMA = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [6:0]  mix_percent;
		logic        b_is_none;
		logic        a_is_none;
		logic [23:0] color_c;
		logic [23:0] color_b;
		logic [23:0] color_a;
		cmd_t        command;
	} in_t;

	typedef struct packed {
		logic [7:0]  gray_level;
		logic        result_is_none;
		logic [23:0] result_color;
	} out_t;

	// Per-item info that travels beside the channel lanes.
	typedef struct packed {
		logic        luma;
		logic        bypass;
		logic        none;
		logic [23:0] color;
		logic [7:0]  gray;
	} side_t;

	// Partial floor square root: remainder and root bits found so far.
	typedef struct packed {
		logic [9:0] rem;
		logic [7:0] root;
	} isq_t;

	localparam int NUM_LANES   = 3;
	localparam int ISQ_STAGES  = 4;
	localparam int PIPE_DEPTH  = 8;
	localparam int SUM_W       = 23;

	localparam logic [6:0]  PCT_FULL   = 7'd100;
	localparam logic [6:0]  DIV_THREE  = 7'd3;
	localparam logic [6:0]  DIV_TWO    = 7'd2;
	localparam logic [18:0] RECIP3     = 19'd349525;  // floor(2^20 / 3)
	localparam logic [15:0] RECIP100   = 16'd41943;   // floor(2^22 / 100)
	localparam logic [14:0] LUMA_RECIP = 15'd20971;   // floor(2^21 / 100)
	localparam logic [5:0]  LUMA_R     = 6'd30;
	localparam logic [5:0]  LUMA_G     = 6'd59;
	localparam logic [5:0]  LUMA_B     = 6'd11;

	function automatic isq_t isqrt_step(isq_t cur, logic [1:0] pair);
		logic [11:0] rem_w;
		logic [11:0] trial;
		isq_t        nxt;
		rem_w = {cur.rem, pair};
		trial = {2'b00, cur.root, 2'b01};
		if (rem_w >= trial) begin
			nxt.rem  = 10'(rem_w - trial);
			nxt.root = {cur.root[6:0], 1'b1};
		end else begin
			nxt.rem  = rem_w[9:0];
			nxt.root = {cur.root[6:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

@@ hw/rtl/rqcb_lane.sv @@
// One color channel lane: squares, weighted mean, constant divide, 8-bit sqrt.
// Eight stages, all advanced by en. Depends on rqcb_pkg.
`timescale 1ns / 1ps

module rqcb_lane (
	input  logic          clk,
	input  logic          en,
	input  rqcb_pkg::cmd_t cmd,
	input  logic [7:0]    chan_a,
	input  logic [7:0]    chan_b,
	input  logic [7:0]    chan_c,
	input  logic [6:0]    pct,
	output logic [7:0]    result
);
	import rqcb_pkg::*;

	logic [15:0]      sq_a_s1, sq_b_s1, sq_c_s1;
	logic [6:0]       pct_s1;
	cmd_t             cmd_s1, cmd_s2, cmd_s3;
	logic [SUM_W-1:0] sum_s2, sum_s3;
	logic [SUM_W-1:0] sum_nxt;
	logic [15:0]      q0_s3, q0_nxt;
	logic [36:0]      prod3;
	logic [38:0]      prod100;
	logic [6:0]       div_d;
	logic [SUM_W-1:0] rem_full;
	logic [15:0]      q_fix;

	// sqrt pipe: index 0 is the corrected mean (stage 4), 1..4 are stages 5..8
	logic [15:0] x_s    [0:ISQ_STAGES];
	logic [9:0]  rem_s  [0:ISQ_STAGES];
	logic [7:0]  root_s [0:ISQ_STAGES];
	logic [15:0] x_n    [1:ISQ_STAGES];
	logic [9:0]  rem_n  [1:ISQ_STAGES];
	logic [7:0]  root_n [1:ISQ_STAGES];

	always_comb begin
		unique case (cmd_s1)
			CMD_AVG2: sum_nxt = SUM_W'(sq_a_s1) + SUM_W'(sq_b_s1);
			CMD_AVG3: sum_nxt = SUM_W'(sq_a_s1) + SUM_W'(sq_b_s1) + SUM_W'(sq_c_s1);
			CMD_MIX:  sum_nxt = SUM_W'(sq_a_s1) * SUM_W'(pct_s1)
				+ SUM_W'(sq_b_s1) * SUM_W'(PCT_FULL - pct_s1);
			default:  sum_nxt = '0;
		endcase
	end

	// reciprocal estimate is exact or one low; stage 4 fixes it
	always_comb begin
		prod3   = 37'(sum_s2[17:0]) * 37'(RECIP3);
		prod100 = 39'(sum_s2) * 39'(RECIP100);
		unique case (cmd_s2)
			CMD_AVG2: q0_nxt = sum_s2[16:1];
			CMD_AVG3: q0_nxt = prod3[35:20];
			CMD_MIX:  q0_nxt = prod100[37:22];
			default:  q0_nxt = '0;
		endcase
	end

	always_comb begin
		unique case (cmd_s3)
			CMD_AVG2: div_d = DIV_TWO;
			CMD_AVG3: div_d = DIV_THREE;
			CMD_MIX:  div_d = PCT_FULL;
			default:  div_d = PCT_FULL;
		endcase
		rem_full = sum_s3 - SUM_W'(q0_s3) * SUM_W'(div_d);
		q_fix    = q0_s3 + 16'(rem_full >= SUM_W'(div_d));
	end

	always_comb begin
		isq_t st_a, st_b;
		for (int g = 1; g <= ISQ_STAGES; g++) begin
			st_a      = isqrt_step('{rem: rem_s[g-1], root: root_s[g-1]}, x_s[g-1][15:14]);
			st_b      = isqrt_step(st_a, x_s[g-1][13:12]);
			x_n[g]    = {x_s[g-1][11:0], 4'b0000};
			rem_n[g]  = st_b.rem;
			root_n[g] = st_b.root;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_a_s1 <= 16'(chan_a) * 16'(chan_a);
			sq_b_s1 <= 16'(chan_b) * 16'(chan_b);
			sq_c_s1 <= 16'(chan_c) * 16'(chan_c);
			pct_s1  <= (pct > PCT_FULL) ? PCT_FULL : pct;
			cmd_s1  <= cmd;
			sum_s2  <= sum_nxt;
			cmd_s2  <= cmd_s1;
			sum_s3  <= sum_s2;
			q0_s3   <= q0_nxt;
			cmd_s3  <= cmd_s2;
			x_s[0]    <= q_fix;
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			for (int g = 1; g <= ISQ_STAGES; g++) begin
				x_s[g]    <= x_n[g];
				rem_s[g]  <= rem_n[g];
				root_s[g] <= root_n[g];
			end
		end
	end

	assign result = root_s[ISQ_STAGES];

endmodule

@@ hw/rtl/rqcb_side.sv @@
// Side path: pass-through cases of the two-color average and luminance of
// color_a, delayed to line up with the lanes. Depends on rqcb_pkg.
`timescale 1ns / 1ps

module rqcb_side (
	input  logic           clk,
	input  logic           en,
	input  rqcb_pkg::cmd_t cmd,
	input  logic [23:0]    color_a,
	input  logic [23:0]    color_b,
	input  logic           a_is_none,
	input  logic           b_is_none,
	output rqcb_pkg::side_t side
);
	import rqcb_pkg::*;

	localparam int DLY = PIPE_DEPTH - 3;

	logic [7:0]  ch_r, ch_g, ch_b;
	side_t       info_s1, info_s2, info_s3;
	logic [14:0] wsum_s1, wsum_s2;
	logic        flat_s1, flat_s2;
	logic [7:0]  red_s1, red_s2;
	logic [29:0] prod;
	logic [7:0]  q0_s2;
	logic [14:0] rem_w;
	logic [7:0]  gray_nxt;
	side_t       dly_q [0:DLY-1];

	assign ch_r = color_a[7:0];
	assign ch_g = color_a[15:8];
	assign ch_b = color_a[23:16];

	assign prod = 30'(wsum_s1) * 30'(LUMA_RECIP);

	always_comb begin
		rem_w    = wsum_s2 - 15'(q0_s2) * 15'(PCT_FULL);
		gray_nxt = flat_s2 ? red_s2 : q0_s2 + 8'(rem_w >= 15'(PCT_FULL));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			info_s1.luma   <= (cmd == CMD_LUMA);
			info_s1.bypass <= (cmd == CMD_AVG2) && (a_is_none || b_is_none);
			info_s1.none   <= (cmd == CMD_AVG2) && a_is_none && b_is_none;
			info_s1.color  <= a_is_none ? color_b : color_a;
			info_s1.gray   <= '0;
			wsum_s1 <= 15'(ch_r) * 15'(LUMA_R) + 15'(ch_g) * 15'(LUMA_G)
				+ 15'(ch_b) * 15'(LUMA_B);
			flat_s1 <= (ch_r == ch_g) && (ch_r == ch_b);
			red_s1  <= ch_r;

			info_s2 <= info_s1;
			wsum_s2 <= wsum_s1;
			flat_s2 <= flat_s1;
			red_s2  <= red_s1;
			q0_s2   <= prod[28:21];

			info_s3 <= {info_s2.luma, info_s2.bypass, info_s2.none, info_s2.color, gray_nxt};

			dly_q[0] <= info_s3;
			for (int i = 1; i < DLY; i++) begin
				dly_q[i] <= dly_q[i-1];
			end
		end
	end

	assign side = dly_q[DLY-1];

endmodule

@@ hw/rtl/rgb_quadratic_color_blend_core.sv @@
// Top level of the RMS color blend: three channel lanes, side path, merge and
// output register. Depends on rqcb_pkg, rqcb_lane and rqcb_side.
//
// Usage:
//   Input channel in_valid/in_ready/in_data carries one beat per item: command,
//   three packed colors (red in the low byte), absent flags and mix percent.
//   Output channel out_valid/out_ready/out_data returns exactly one beat per
//   item, in order: blended color, none flag and gray level.
//   Each channel of the color runs in its own lane (square, weighted mean,
//   reciprocal divide, four-stage floor square root, two result bits a stage);
//   the merge picks lane results, pass-through color or luminance.
//   A beat passes through the lane stages and then the output register before
//   out_valid rises. Throughput is one beat per cycle while out_ready stays high.
//   When the receiver stalls, the output register holds its beat and the whole
//   pipeline freezes; in_ready drops only while the output is full and stalled.
//   Reset clears all valid flags; no beat is presented until one is accepted.
`timescale 1ns / 1ps

module rgb_quadratic_color_blend_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rqcb_pkg::in_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rqcb_pkg::out_t out_data
);
	import rqcb_pkg::*;

	logic                  en;
	logic [PIPE_DEPTH-1:0] vld_q;
	logic                  out_valid_q;
	out_t                  out_q;
	out_t                  merged;
	side_t                 side;
	logic [7:0]            lane_res [0:NUM_LANES-1];
	logic [23:0]           lane_color;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
		rqcb_lane u_lane (
			.clk    (clk),
			.en     (en),
			.cmd    (in_data.command),
			.chan_a (in_data.color_a[8*k +: 8]),
			.chan_b (in_data.color_b[8*k +: 8]),
			.chan_c (in_data.color_c[8*k +: 8]),
			.pct    (in_data.mix_percent),
			.result (lane_res[k])
		);
		assign lane_color[8*k +: 8] = lane_res[k];
	end

	rqcb_side u_side (
		.clk       (clk),
		.en        (en),
		.cmd       (in_data.command),
		.color_a   (in_data.color_a),
		.color_b   (in_data.color_b),
		.a_is_none (in_data.a_is_none),
		.b_is_none (in_data.b_is_none),
		.side      (side)
	);

	always_comb begin
		merged.gray_level     = side.luma ? side.gray : 8'd0;
		merged.result_is_none = side.none;
		priority if (side.luma) begin
			merged.result_color = '0;
		end else if (side.bypass) begin
			merged.result_color = side.color;
		end else begin
			merged.result_color = lane_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[PIPE_DEPTH-2:0], in_valid};
			out_valid_q <= vld_q[PIPE_DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q <= merged;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// an accepted beat enters the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[0])
		else $error("accepted beat lost at pipeline entry");

	// a beat leaving the last stage reaches the output register
	a_last_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[PIPE_DEPTH-1] && en) |=> out_valid_q)
		else $error("beat dropped between last stage and output");

	// luminance and color results never both nonzero
	a_modes_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.gray_level == 8'd0 || out_q.result_color == 24'd0))
		else $error("gray level and color both set");

endmodule

@@ dv/tb_rgb_quadratic_color_blend_core.sv @@
// Self-checking testbench for rgb_quadratic_color_blend_core: directed corners, per-command
// runs and a mixed random stream, checked against an in-bench RMS blend predictor.
// Depends on rqcb_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_rgb_quadratic_color_blend_core;

	import rqcb_pkg::*;

	localparam int unsigned FULL_PCT   = 100;
	localparam int unsigned WT_RED     = 30;
	localparam int unsigned WT_GREEN   = 59;
	localparam int unsigned WT_BLUE    = 11;
	localparam int          CYCLE_CAP  = 200000;
	localparam int          TAIL_WAIT  = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	out_t pending_blends[$];
	int   error_count = 0;
	int   cycle_count = 0;
	int   stall_left = 0;
	bit   tx_quiet = 1'b0;
	bit   rx_quiet = 1'b0;

	rgb_quadratic_color_blend_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_blends.size());
			$display("tb_rgb_quadratic_color_blend_core NOT OK");
			$finish;
		end
	end

	// Expected blend of one input beat.
	function automatic out_t predict_blend(in_t item);
		out_t        res;
		int unsigned pct;
		int unsigned av, bv, cv;
		int unsigned mean_sq;
		int unsigned root;
		int unsigned trial;
		res = '0;
		pct = (item.mix_percent > FULL_PCT) ? FULL_PCT : int'(item.mix_percent);
		if (item.command == CMD_LUMA) begin
			av = item.color_a[7:0];
			bv = item.color_a[15:8];
			cv = item.color_a[23:16];
			if (av == bv && av == cv)
				res.gray_level = av[7:0];
			else
				res.gray_level = 8'((av * WT_RED + bv * WT_GREEN + cv * WT_BLUE) / FULL_PCT);
		end else if (item.command == CMD_AVG2 && item.a_is_none) begin
			res.result_color   = item.color_b;
			res.result_is_none = item.b_is_none;
		end else if (item.command == CMD_AVG2 && item.b_is_none) begin
			res.result_color = item.color_a;
		end else begin
			for (int k = 0; k < 3; k++) begin
				av = item.color_a[8*k +: 8];
				bv = item.color_b[8*k +: 8];
				cv = item.color_c[8*k +: 8];
				case (item.command)
					CMD_AVG2: mean_sq = (av * av + bv * bv) / 2;
					CMD_AVG3: mean_sq = (av * av + bv * bv + cv * cv) / 3;
					default:  mean_sq = (av * av * pct + bv * bv * (FULL_PCT - pct)) / FULL_PCT;
				endcase
				// floor square root, one root bit per pass from the top
				root = 0;
				for (int b = 7; b >= 0; b--) begin
					trial = root | (32'd1 << b);
					if (trial * trial <= mean_sq)
						root = trial;
				end
				res.result_color[8*k +: 8] = root[7:0];
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	task automatic check_blend(input out_t got);
		out_t want;
		if (pending_blends.size() == 0) begin
			report_mismatch($sformatf("result beat %h with no item pending", got));
		end else begin
			want = pending_blends.pop_front();
			if (got.result_color !== want.result_color)
				report_mismatch($sformatf("result_color got %h expected %h",
					got.result_color, want.result_color));
			if (got.result_is_none !== want.result_is_none)
				report_mismatch($sformatf("result_is_none got %b expected %b",
					got.result_is_none, want.result_is_none));
			if (got.gray_level !== want.gray_level)
				report_mismatch($sformatf("gray_level got %h expected %h",
					got.gray_level, want.gray_level));
		end
	endtask

	// Receiver: random stall, possibly none, after each accepted beat; none while rx_quiet is set.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			check_blend(out_data);
			stall_left = rx_quiet ? 0 : $urandom_range(0, 6);
		end else if (stall_left > 0) begin
			stall_left--;
		end
		out_ready <= arst_n && (stall_left == 0);
	end

	// This task lowers valid only on a gap, so back-to-back beats never toggle it in one step.
	task automatic send_beat(input in_t item);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		pending_blends = {pending_blends, predict_blend(item)};
	endtask

	// Sender holds off until every result is back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_blends.size() != 0) @(posedge clk);
	endtask

	function automatic in_t make_item(cmd_t cmd, logic [23:0] a, logic [23:0] b,
		logic [23:0] c, logic an, logic bn, logic [6:0] pct);
		in_t item;
		item.command     = cmd;
		item.color_a     = a;
		item.color_b     = b;
		item.color_c     = c;
		item.a_is_none   = an;
		item.b_is_none   = bn;
		item.mix_percent = pct;
		return item;
	endfunction

	// Bytes lean toward 00 and FF so channel extremes show up often.
	function automatic logic [23:0] rand_color();
		logic [23:0] col;
		for (int k = 0; k < 3; k++) begin
			case ($urandom_range(0, 7))
				0:       col[8*k +: 8] = 8'h00;
				1:       col[8*k +: 8] = 8'hFF;
				default: col[8*k +: 8] = 8'($urandom_range(0, 255));
			endcase
		end
		return col;
	endfunction

	function automatic in_t rand_item(cmd_t cmd);
		in_t item;
		item = make_item(cmd, rand_color(), rand_color(), rand_color(),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 7'($urandom_range(0, 100)));
		// mostly plain averages; random absent flags kept on a quarter of them
		if (cmd == CMD_AVG2 && $urandom_range(0, 3) != 0) begin
			item.a_is_none = 1'b0;
			item.b_is_none = 1'b0;
		end
		if ($urandom_range(0, 7) == 0)
			item.mix_percent = 7'($urandom_range(101, 127));
		if (cmd == CMD_LUMA && $urandom_range(0, 3) == 0)
			item.color_a = {3{item.color_a[7:0]}};
		return item;
	endfunction

	task automatic test_corner_items();
		send_beat(make_item(CMD_AVG2, 24'h000000, 24'hFFFFFF, 24'h000000, 1'b0, 1'b0, 7'd0));
		send_beat(make_item(CMD_AVG2, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0, 7'd127));
		send_beat(make_item(CMD_AVG2, 24'h000000, 24'h000000, 24'hFFFFFF, 1'b0, 1'b0, 7'd50));
		// absent color_a, both absent, absent color_b
		send_beat(make_item(CMD_AVG2, 24'hABCDEF, 24'h123456, 24'h0, 1'b1, 1'b0, 7'd0));
		send_beat(make_item(CMD_AVG2, 24'hABCDEF, 24'h123456, 24'h0, 1'b1, 1'b1, 7'd0));
		send_beat(make_item(CMD_AVG2, 24'hABCDEF, 24'h123456, 24'h0, 1'b0, 1'b1, 7'd0));
		send_beat(make_item(CMD_AVG3, 24'hFFFFFF, 24'h000000, 24'h000000, 1'b0, 1'b0, 7'd0));
		send_beat(make_item(CMD_AVG3, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0, 7'd0));
		// flags carry no meaning outside the two-color average
		send_beat(make_item(CMD_AVG3, 24'h10FF80, 24'hFF0010, 24'h7F7F7F, 1'b1, 1'b1, 7'd9));
		send_beat(make_item(CMD_MIX, 24'hFFFFFF, 24'h000000, 24'h0, 1'b0, 1'b0, 7'd0));
		send_beat(make_item(CMD_MIX, 24'hFFFFFF, 24'h000000, 24'h0, 1'b0, 1'b0, 7'd100));
		send_beat(make_item(CMD_MIX, 24'h00FF00, 24'hFF00FF, 24'h0, 1'b0, 1'b0, 7'd50));
		// percent above one hundred saturates
		send_beat(make_item(CMD_MIX, 24'h123456, 24'hFEDCBA, 24'h0, 1'b0, 1'b0, 7'd101));
		send_beat(make_item(CMD_MIX, 24'h123456, 24'hFEDCBA, 24'h0, 1'b1, 1'b1, 7'd127));
		send_beat(make_item(CMD_MIX, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0, 7'd1));
		send_beat(make_item(CMD_LUMA, 24'h000000, 24'h0, 24'h0, 1'b0, 1'b0, 7'd0));
		send_beat(make_item(CMD_LUMA, 24'hFFFFFF, 24'h0, 24'h0, 1'b0, 1'b0, 7'd0));
		send_beat(make_item(CMD_LUMA, 24'h808080, 24'h0, 24'h0, 1'b0, 1'b0, 7'd0));
		send_beat(make_item(CMD_LUMA, 24'h0000FF, 24'h0, 24'h0, 1'b0, 1'b0, 7'd0));
		send_beat(make_item(CMD_LUMA, 24'h00FF00, 24'h0, 24'h0, 1'b0, 1'b0, 7'd0));
		send_beat(make_item(CMD_LUMA, 24'hFF0000, 24'h0, 24'h0, 1'b0, 1'b0, 7'd0));
		send_beat(make_item(CMD_LUMA, 24'hFFFEFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 7'd127));
		send_beat(make_item(CMD_LUMA, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 7'd127));
	endtask

	task automatic test_command_runs(input int per_cmd);
		cmd_t cmd;
		cmd = CMD_AVG2;
		for (int n = 0; n < 4; n++) begin
			tx_quiet = (n == 1);
			rx_quiet = (n == 2);
			for (int i = 0; i < per_cmd; i++)
				send_beat(rand_item(cmd));
			drain_results();
			cmd = cmd.next();
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	task automatic test_mixed_stream(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 96 == 0) begin
				tx_quiet = ($urandom_range(0, 2) == 0);
				rx_quiet = ($urandom_range(0, 2) == 0);
			end
			send_beat(rand_item(cmd_t'($urandom_range(0, 3))));
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_items();
		drain_results();
		test_command_runs(150);
		test_mixed_stream(430);
		while (pending_blends.size() != 0) @(posedge clk);
		repeat (TAIL_WAIT) @(posedge clk);
		if (error_count == 0)
			$display("tb_rgb_quadratic_color_blend_core OK");
		else
			$display("tb_rgb_quadratic_color_blend_core NOT OK");
		$finish;
	end

endmodule
